// File: hw/rtl/etfp_pkg.sv
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types, constants and fixed-point helpers of the escape-time pixel
// engine.
// ----------------------------------------------------------------------------
package etfp_pkg;

  localparam int unsigned PixW     = 10;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DefImageWidth = 1024;
  localparam int unsigned DefMaxOrder   = 8;

  // Q4.28 constants
  localparam logic signed [63:0] QHalf    = 64'sd134217728;
  localparam logic signed [31:0] QOne     = 32'sd268435456;
  localparam logic signed [31:0] QQuarter = 32'sd67108864;

  // register indexes
  typedef enum logic [2:0] {
    CFG_LEFT_EDGE   = 3'd0,
    CFG_TOP_EDGE    = 3'd1,
    CFG_X_STEP      = 3'd2,
    CFG_Y_STEP      = 3'd3,
    CFG_MAX_ITER    = 3'd4,
    CFG_POWER_ORDER = 3'd5,
    CFG_BAILOUT_SQ  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] left_edge;
    logic signed [31:0] top_edge;
    logic [30:0]        x_step;
    logic [30:0]        y_step;
    logic [15:0]        max_iter;
    logic [3:0]         power_order;
    logic [31:0]        bailout_sq;
  } cfg_t;

  // one point of the complex plane, passed from front to engine
  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } point_t;

  // queue handshake towards the engine
  typedef struct packed {
    logic   empty;
    point_t head;
  } q_rd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CARD0,
    ST_CARD1,
    ST_CARD2,
    ST_CARD3,
    ST_CARD4,
    ST_MAG0,
    ST_MAG1,
    ST_MAG2,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_DONE
  } eng_state_e;

  // round a Q8.56 product to Q8.28, ties upward
  function automatic logic signed [35:0] rnd_q(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + QHalf;
    return t[63:28];
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -44'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // clamp a magnitude to the unsigned 32-bit range
  function automatic logic [31:0] satu32(input logic signed [43:0] v);
    if (v < 44'sd0) begin
      return 32'h0;
    end else if (v > 44'sd4294967295) begin
      return 32'hFFFF_FFFF;
    end
    return v[31:0];
  endfunction

endpackage

// File: hw/rtl/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Escape-time iteration for one pixel per transaction: maps the pixel onto
// the plane, iterates z = z^order + c and reports count, inside flag and
// the final squared magnitude.
//
//   channel   direction  handshake          payload
//   pixel     in         push / full        pixel_row_i, pixel_col_i
//   result    out        empty / pop        escape_count_o, inside_set_o,
//                                           final_mag_sq_o
//   config    in         cfg_valid_i/ready  cfg_index_i, cfg_data_i
//
// The front takes a pixel every cycle into a two-entry queue. The engine
// shares one 32x32 multiplier: a setup sequence (with the cardioid test
// for order two), then per iteration a magnitude check and order-1 complex
// multiplies, and a final state that hands over the result.
// Reset clears all control state; configuration returns to its defaults.
// The front stalls only when the queue is full; the engine waits in its
// last state while the result register still holds an untaken result.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel import etfp_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH = DefImageWidth,
  parameter int unsigned MAX_ORDER   = DefMaxOrder
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [PixW-1:0]   pixel_row_i,
  input  logic [PixW-1:0]   pixel_col_i,
  output logic              empty,
  input  logic              pop,
  output logic [CountW-1:0] escape_count_o,
  output logic              inside_set_o,
  output logic [31:0]       final_mag_sq_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  cfg_t   cfg_q;
  logic   q_wr, q_full, q_rd;
  point_t q_data;
  q_rd_t  q_rd_s;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge   <= -32'sd536870912;
      cfg_q.top_edge    <= 32'sd536870912;
      cfg_q.x_step      <= 31'd524288;
      cfg_q.y_step      <= 31'd524288;
      cfg_q.max_iter    <= 16'd256;
      cfg_q.power_order <= 4'd2;
      cfg_q.bailout_sq  <= 32'd1073741824;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LEFT_EDGE:   cfg_q.left_edge   <= cfg_data_i;
        CFG_TOP_EDGE:    cfg_q.top_edge    <= cfg_data_i;
        CFG_X_STEP:      cfg_q.x_step      <= cfg_data_i[30:0];
        CFG_Y_STEP:      cfg_q.y_step      <= cfg_data_i[30:0];
        CFG_MAX_ITER:    cfg_q.max_iter    <= cfg_data_i[15:0];
        CFG_POWER_ORDER: cfg_q.power_order <= cfg_data_i[3:0];
        CFG_BAILOUT_SQ:  cfg_q.bailout_sq  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  etfp_front #(.IMAGE_WIDTH(IMAGE_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .full_o   (full),
    .row_i    (pixel_row_i),
    .col_i    (pixel_col_i),
    .q_wr_o   (q_wr),
    .q_data_o (q_data),
    .q_full_i (q_full)
  );

  etfp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_data),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_o      (q_rd_s)
  );

  etfp_engine #(.MAX_ORDER(MAX_ORDER)) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_i      (q_rd_s),
    .q_rd_o   (q_rd),
    .empty_o  (empty),
    .pop_i    (pop),
    .count_o  (escape_count_o),
    .inside_o (inside_set_o),
    .mag_o    (final_mag_sq_o)
  );

endmodule

// File: hw/rtl/etfp_queue.sv
// ----------------------------------------------------------------------------
// etfp_queue
// Two-entry queue of plane points between the front and the engine.
// ----------------------------------------------------------------------------
module etfp_queue import etfp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  point_t wr_data_i,
  output logic   full_o,
  input  logic   rd_i,
  output q_rd_t  rd_o
);

  point_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q[1];
  assign rd_o.empty = (cnt_q == 2'd0);
  assign rd_o.head  = mem_q[rd_ptr_q];

  // store incoming points
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

endmodule

// File: hw/rtl/etfp_front.sv
// ----------------------------------------------------------------------------
// etfp_front
// Clamps the pixel indexes and maps them onto the complex plane in two
// stages: products first, then offset and saturation.
// ----------------------------------------------------------------------------
module etfp_front import etfp_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH = DefImageWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            push_i,
  output logic            full_o,
  input  logic [PixW-1:0] row_i,
  input  logic [PixW-1:0] col_i,
  output logic            q_wr_o,
  output point_t          q_data_o,
  input  logic            q_full_i
);

  localparam int unsigned LastIdx = IMAGE_WIDTH - 1;

  logic [PixW-1:0] row_c, col_c;
  logic            v_q;
  logic [40:0]     px_q, py_q;
  logic            accept;

  // clamp indexes beyond the image
  always_comb begin
    row_c = row_i;
    col_c = col_i;
    if (32'(row_i) > LastIdx) row_c = PixW'(LastIdx);
    if (32'(col_i) > LastIdx) col_c = PixW'(LastIdx);
  end

  assign full_o = v_q && q_full_i;
  assign accept = push_i && !full_o;
  assign q_wr_o = v_q && !q_full_i;

  // form the offsets
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= 41'(col_c) * 41'(cfg_i.x_step);
      py_q <= 41'(row_c) * 41'(cfg_i.y_step);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (accept) begin
      v_q <= 1'b1;
    end else if (q_wr_o) begin
      v_q <= 1'b0;
    end
  end

  // add the view edges and saturate
  always_comb begin
    q_data_o.cr = sat32(44'(cfg_i.left_edge) + $signed({3'b0, px_q}));
    q_data_o.ci = sat32(44'(cfg_i.top_edge) - $signed({3'b0, py_q}));
  end

endmodule

// File: hw/rtl/etfp_engine.sv
// ----------------------------------------------------------------------------
// etfp_engine
// Iterates z = z^order + c for one point at a time on a single shared
// 32x32 multiplier, with the cardioid shortcut for order two, and holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module etfp_engine import etfp_pkg::*; #(
  parameter int unsigned MAX_ORDER = DefMaxOrder
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  q_rd_t             q_i,
  output logic              q_rd_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [CountW-1:0] count_o,
  output logic              inside_o,
  output logic [31:0]       mag_o
);

  localparam int unsigned OrdW = $clog2(MAX_ORDER + 1);

  eng_state_e state_q, state_d;

  logic signed [31:0] cr_q, ci_q, zr_q, zi_q, wr_q, wi_q, tre_q, q_q;
  logic signed [31:0] cr_d, ci_d, zr_d, zi_d, wr_d, wi_d, tre_d, q_d;
  logic signed [35:0] acc_q, acc_d;
  logic [CountW-1:0]  k_q, k_d;
  logic [OrdW-1:0]    e_q, e_d;
  logic [31:0]        mag_q, mag_d;
  logic signed [63:0] prod_q;
  logic signed [31:0] op_a, op_b, xq;
  logic signed [35:0] r;
  logic signed [31:0] ni;
  logic [OrdW-1:0]    eff_ord;
  logic               near;

  logic               res_v_q;
  logic [CountW-1:0]  res_cnt_q;
  logic               res_in_q;
  logic [31:0]        res_mag_q;
  logic               res_load;

  // clamp the order to its supported range
  always_comb begin
    if (cfg_i.power_order < 4'd2) begin
      eff_ord = OrdW'(2);
    end else if (32'(cfg_i.power_order) > MAX_ORDER) begin
      eff_ord = OrdW'(MAX_ORDER);
    end else begin
      eff_ord = OrdW'(cfg_i.power_order);
    end
  end

  assign xq   = cr_q - QQuarter;
  assign r    = rnd_q(prod_q);
  assign near = (cr_q <= QOne) && (cr_q >= -QOne) && (ci_q <= QOne) && (ci_q >= -QOne);
  assign ni   = sat32(44'(acc_q) + 44'(r));

  // pick multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      ST_CARD0: begin op_a = ci_q; op_b = ci_q;      end
      ST_CARD1: begin op_a = xq;   op_b = xq;        end
      ST_CARD3: begin op_a = q_q;  op_b = q_q + xq;  end
      ST_MAG0:  begin op_a = zr_q; op_b = zr_q;      end
      ST_MAG1:  begin op_a = zi_q; op_b = zi_q;      end
      ST_C0:    begin op_a = wr_q; op_b = zr_q;      end
      ST_C1:    begin op_a = wi_q; op_b = zi_q;      end
      ST_C2:    begin op_a = wr_q; op_b = zi_q;      end
      ST_C3:    begin op_a = wi_q; op_b = zr_q;      end
      default:  begin op_a = '0;   op_b = '0;        end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
  end

  // sequence the iteration
  always_comb begin
    state_d  = state_q;
    cr_d = cr_q;  ci_d = ci_q;
    zr_d = zr_q;  zi_d = zi_q;
    wr_d = wr_q;  wi_d = wi_q;
    tre_d = tre_q; q_d = q_q;
    acc_d = acc_q;
    k_d = k_q;
    e_d = e_q;
    mag_d = mag_q;
    q_rd_o = 1'b0;
    res_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_i.empty) begin
          q_rd_o = 1'b1;
          cr_d = q_i.head.cr;  ci_d = q_i.head.ci;
          zr_d = q_i.head.cr;  zi_d = q_i.head.ci;
          k_d  = '0;
          state_d = ST_CARD0;
        end
      end
      ST_CARD0: begin
        state_d = (eff_ord == OrdW'(2) && near) ? ST_CARD1 : ST_MAG0;
      end
      ST_CARD1: begin
        acc_d = r;
        state_d = ST_CARD2;
      end
      ST_CARD2: begin
        q_d = 32'(r + acc_q);
        state_d = ST_CARD3;
      end
      ST_CARD3: state_d = ST_CARD4;
      ST_CARD4: begin
        // signed compare: the product term goes negative near the cusp
        if ($signed({r, 2'b00}) <= 38'(acc_q)) k_d = cfg_i.max_iter;
        state_d = ST_MAG0;
      end
      ST_MAG0: state_d = ST_MAG1;
      ST_MAG1: begin
        acc_d = r;
        state_d = ST_MAG2;
      end
      ST_MAG2: begin
        mag_d = satu32(44'(acc_q) + 44'(r));
        if (k_q < cfg_i.max_iter && mag_d < cfg_i.bailout_sq) begin
          wr_d = zr_q;  wi_d = zi_q;
          e_d = OrdW'(1);
          state_d = ST_C0;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_C0: state_d = ST_C1;
      ST_C1: begin
        acc_d = r;
        state_d = ST_C2;
      end
      ST_C2: begin
        tre_d = sat32(44'(acc_q) - 44'(r));
        state_d = ST_C3;
      end
      ST_C3: begin
        acc_d = r;
        state_d = ST_C4;
      end
      ST_C4: begin
        if (e_q + OrdW'(1) < eff_ord) begin
          wr_d = tre_q;  wi_d = ni;
          e_d = e_q + OrdW'(1);
          state_d = ST_C0;
        end else begin
          zr_d = sat32(44'(tre_q) + 44'(cr_q));
          zi_d = sat32(44'(ni) + 44'(ci_q));
          k_d  = k_q + CountW'(1);
          state_d = ST_MAG0;
        end
      end
      ST_DONE: begin
        if (!res_v_q || pop_i) begin
          res_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // hold the working point
  always_ff @(posedge clk_i) begin
    cr_q <= cr_d;  ci_q <= ci_d;
    zr_q <= zr_d;  zi_q <= zi_d;
    wr_q <= wr_d;  wi_q <= wi_d;
    tre_q <= tre_d; q_q <= q_d;
    acc_q <= acc_d;
    k_q <= k_d;
    e_q <= e_d;
    mag_q <= mag_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (res_load) begin
      res_v_q <= 1'b1;
    end else if (pop_i) begin
      res_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_cnt_q <= k_q;
      res_in_q  <= (k_q == cfg_i.max_iter);
      res_mag_q <= mag_q;
    end
  end

  assign empty_o  = !res_v_q;
  assign count_o  = res_cnt_q;
  assign inside_o = res_in_q;
  assign mag_o    = res_mag_q;

  // a waiting point is always taken up
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && !q_i.empty |=> state_q == ST_CARD0)
    else $error("engine left a queued point waiting");

  // the count never passes the limit
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> k_q <= cfg_i.max_iter)
    else $error("iteration count beyond limit");

  // the inside flag tracks the count
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> res_in_q == (res_cnt_q == cfg_i.max_iter))
    else $error("inside flag disagrees with count");

  // a finished result never overwrites one still waiting
  a_nolose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !res_v_q || pop_i)
    else $error("result overwritten");

endmodule
